FILE: design/pff_pkg.sv
`default_nettype none
package pff_pkg;

  // Pipeline layout: input, difference, square, sum, root steps, gain, product,
  // divider steps, output
  localparam int SQ_STEPS  = 15;
  localparam int SQ_FIRST  = 4;
  localparam int E_STG     = SQ_FIRST + SQ_STEPS;
  localparam int DIV_BITS  = 41;
  localparam int DIV_FIRST = E_STG + 2;
  localparam int DIV_LAST  = DIV_FIRST + DIV_BITS;
  localparam int NSTG      = DIV_LAST + 2;

  localparam int NUM_W = 46;
  localparam int DEN_W = 60;
  localparam int NUM_LO_W = 17;

  // Repulsion magnitude cap, 2^40
  localparam logic [DIV_BITS-1:0] REP_CAP = {1'b1, {(DIV_BITS-1){1'b0}}};

  // Smallest squared distance above 0.01 m
  localparam logic [32:0] S_MIN = 33'd7;

  localparam logic [15:0] ATTRACT_GAIN_RST = 16'd256;
  localparam logic [15:0] REPEL_GAIN_RST   = 16'd1280;
  localparam logic [14:0] INFL_RADIUS_RST  = 15'd512;

  typedef enum logic [1:0] {
    CFG_ATTRACT_GAIN     = 2'd0,
    CFG_REPEL_GAIN       = 2'd1,
    CFG_INFLUENCE_RADIUS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [33:0] fx;
    logic signed [33:0] fy;
    logic               active;
    logic               negx;
    logic               negy;
  } side_t;

endpackage
`default_nettype wire

FILE: design/pff_div.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage.
// Quotient of (num << 24) / den, with an overflow flag when it reaches 2^41.
module pff_div (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [pff_pkg::NUM_W-1:0]           num,
  input  wire logic [pff_pkg::DEN_W-1:0]           den,
  output logic      [pff_pkg::DIV_BITS-1:0]        q,
  output logic                                      big
);

  logic [pff_pkg::DEN_W-1:0]    rem_r  [0:pff_pkg::DIV_BITS];
  logic [pff_pkg::DEN_W-1:0]    den_r  [0:pff_pkg::DIV_BITS];
  logic [pff_pkg::NUM_LO_W-1:0] nlo_r  [0:pff_pkg::DIV_BITS];
  logic [pff_pkg::DIV_BITS-1:0] q_r    [0:pff_pkg::DIV_BITS];
  logic                         big_r  [0:pff_pkg::DIV_BITS];

  logic [pff_pkg::DEN_W-1:0] hi_num;
  assign hi_num = {{(pff_pkg::DEN_W - pff_pkg::NUM_W + pff_pkg::NUM_LO_W){1'b0}},
                   num[pff_pkg::NUM_W-1:pff_pkg::NUM_LO_W]};

  // Load the upper numerator bits and flag an oversized quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_num;
      den_r[0] <= den;
      nlo_r[0] <= num[pff_pkg::NUM_LO_W-1:0];
      q_r[0]   <= '0;
      big_r[0] <= (hi_num >= den);
    end
  end

  genvar j;
  generate
    for (j = 1; j <= pff_pkg::DIV_BITS; j++) begin : g_step
      logic [pff_pkg::DEN_W:0] trial;
      logic                    take;
      assign trial = {rem_r[j-1], nlo_r[j-1][pff_pkg::NUM_LO_W-1]};
      assign take  = (trial >= {1'b0, den_r[j-1]});

      // Shift in the next numerator bit and subtract when it fits
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= take ? pff_pkg::DEN_W'(trial - {1'b0, den_r[j-1]})
                           : trial[pff_pkg::DEN_W-1:0];
          den_r[j] <= den_r[j-1];
          nlo_r[j] <= {nlo_r[j-1][pff_pkg::NUM_LO_W-2:0], 1'b0};
          q_r[j]   <= {q_r[j-1][pff_pkg::DIV_BITS-2:0], take};
          big_r[j] <= big_r[j-1];
        end
      end
    end
  endgenerate

  assign q   = q_r[pff_pkg::DIV_BITS];
  assign big = big_r[pff_pkg::DIV_BITS];

endmodule
`default_nettype wire

FILE: design/potential_field_force.sv
`default_nettype none
// Channel   Direction  Handshake             Word
// in_       input      in_valid / in_ready   robot, goal, obstacle positions, Q7.8
// out_      output     out_valid / out_ready force_x/y Q15.16, repulsion_active, saturated
// cfg_      input      cfg_valid / cfg_ready register index and write data
//
// One word per cycle while no result waits on out_ready; the pipeline depth is set by
// the 15-step square root and the 41-bit quotient divider, one bit per stage.
// Reset clears the valid bits and loads the default gains and radius.
// The whole pipeline holds while a result waits on out_ready.
module potential_field_force (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_robot_x,
  input  wire logic signed [15:0] in_robot_y,
  input  wire logic signed [15:0] in_goal_x,
  input  wire logic signed [15:0] in_goal_y,
  input  wire logic signed [15:0] in_obstacle_x,
  input  wire logic signed [15:0] in_obstacle_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_force_x,
  output logic signed [31:0]      out_force_y,
  output logic                    out_repulsion_active,
  output logic                    out_saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int NS = pff_pkg::SQ_STEPS;

  logic [15:0] attract_gain_r;
  logic [15:0] repel_gain_r;
  logic [14:0] infl_radius_r;

  logic en;
  logic vld_r [0:pff_pkg::NSTG-1];

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attract_gain_r <= pff_pkg::ATTRACT_GAIN_RST;
      repel_gain_r   <= pff_pkg::REPEL_GAIN_RST;
      infl_radius_r  <= pff_pkg::INFL_RADIUS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pff_pkg::CFG_ATTRACT_GAIN:     attract_gain_r <= cfg_data;
        pff_pkg::CFG_REPEL_GAIN:       repel_gain_r   <= cfg_data;
        pff_pkg::CFG_INFLUENCE_RADIUS: infl_radius_r  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless the output word is stuck
  assign en       = !vld_r[pff_pkg::NSTG-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pff_pkg::NSTG; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < pff_pkg::NSTG; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Input stage
  logic signed [15:0] a_rx_r, a_ry_r, a_gx_r, a_gy_r, a_ox_r, a_oy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_rx_r <= in_robot_x;
      a_ry_r <= in_robot_y;
      a_gx_r <= in_goal_x;
      a_gy_r <= in_goal_y;
      a_ox_r <= in_obstacle_x;
      a_oy_r <= in_obstacle_y;
    end
  end

  // Differences and attraction
  logic signed [16:0] ddx, ddy, dgx, dgy;
  logic signed [33:0] b_fx_r, b_fy_r;
  logic [15:0]        b_ax_r, b_ay_r;
  logic               b_negx_r, b_negy_r;
  assign ddx = 17'(a_rx_r) - 17'(a_ox_r);
  assign ddy = 17'(a_ry_r) - 17'(a_oy_r);
  assign dgx = 17'(a_gx_r) - 17'(a_rx_r);
  assign dgy = 17'(a_gy_r) - 17'(a_ry_r);
  always_ff @(posedge clk) begin
    if (en) begin
      b_fx_r   <= $signed({1'b0, attract_gain_r}) * dgx;
      b_fy_r   <= $signed({1'b0, attract_gain_r}) * dgy;
      b_ax_r   <= ddx[16] ? 16'(-ddx) : ddx[15:0];
      b_ay_r   <= ddy[16] ? 16'(-ddy) : ddy[15:0];
      b_negx_r <= ddx[16];
      b_negy_r <= ddy[16];
    end
  end

  // Squares
  logic [31:0]        c_sqx_r, c_sqy_r;
  logic [29:0]        c_rr_r;
  logic signed [33:0] c_fx_r, c_fy_r;
  logic [15:0]        c_ax_r, c_ay_r;
  logic               c_negx_r, c_negy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c_sqx_r  <= b_ax_r * b_ax_r;
      c_sqy_r  <= b_ay_r * b_ay_r;
      c_rr_r   <= infl_radius_r * infl_radius_r;
      c_fx_r   <= b_fx_r;
      c_fy_r   <= b_fy_r;
      c_ax_r   <= b_ax_r;
      c_ay_r   <= b_ay_r;
      c_negx_r <= b_negx_r;
      c_negy_r <= b_negy_r;
    end
  end

  // Squared distance and band test
  logic [32:0]    s_sum;
  logic [29:0]    d_s_r;
  logic [14:0]    d_ax_r, d_ay_r;
  pff_pkg::side_t d_side_r;
  assign s_sum = {1'b0, c_sqx_r} + {1'b0, c_sqy_r};
  always_ff @(posedge clk) begin
    if (en) begin
      d_s_r           <= s_sum[29:0];
      d_ax_r          <= c_ax_r[14:0];
      d_ay_r          <= c_ay_r[14:0];
      d_side_r.fx     <= c_fx_r;
      d_side_r.fy     <= c_fy_r;
      d_side_r.active <= (s_sum >= pff_pkg::S_MIN) && (s_sum < {3'b0, c_rr_r});
      d_side_r.negx   <= c_negx_r;
      d_side_r.negy   <= c_negy_r;
    end
  end

  // Side data delay to the output stage
  pff_pkg::side_t sd_r [pff_pkg::SQ_FIRST:pff_pkg::DIV_LAST];
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[pff_pkg::SQ_FIRST] <= d_side_r;
      for (int i = pff_pkg::SQ_FIRST + 1; i <= pff_pkg::DIV_LAST; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // Square root, two radicand bits per stage
  logic [29:0] sq_v_r   [0:NS-1];
  logic [29:0] sq_res_r [0:NS-1];
  logic [29:0] sq_s_r   [0:NS-1];
  logic [14:0] sq_ax_r  [0:NS-1];
  logic [14:0] sq_ay_r  [0:NS-1];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_sqrt
      localparam logic [29:0] BIT = 30'd1 << (28 - 2 * k);
      logic [29:0] v_in, res_in, s_in;
      logic [14:0] ax_in, ay_in;
      logic [30:0] trial;
      if (k == 0) begin : g_head
        assign v_in   = d_s_r;
        assign res_in = '0;
        assign s_in   = d_s_r;
        assign ax_in  = d_ax_r;
        assign ay_in  = d_ay_r;
      end else begin : g_body
        assign v_in   = sq_v_r[k-1];
        assign res_in = sq_res_r[k-1];
        assign s_in   = sq_s_r[k-1];
        assign ax_in  = sq_ax_r[k-1];
        assign ay_in  = sq_ay_r[k-1];
      end
      assign trial = {1'b0, res_in} + {1'b0, BIT};

      always_ff @(posedge clk) begin
        if (en) begin
          if ({1'b0, v_in} >= trial) begin
            sq_v_r[k]   <= 30'({1'b0, v_in} - trial);
            sq_res_r[k] <= (res_in >> 1) + BIT;
          end else begin
            sq_v_r[k]   <= v_in;
            sq_res_r[k] <= res_in >> 1;
          end
          sq_s_r[k]  <= s_in;
          sq_ax_r[k] <= ax_in;
          sq_ay_r[k] <= ay_in;
        end
      end
    end
  endgenerate

  // Gain times remaining distance, distance times radius
  logic [14:0] root_d, rad_gap;
  logic [30:0] e_base_r;
  logic [29:0] e_dr_r, e_s_r;
  logic [14:0] e_ax_r, e_ay_r;
  assign root_d  = sq_res_r[NS-1][14:0];
  assign rad_gap = infl_radius_r - root_d;
  always_ff @(posedge clk) begin
    if (en) begin
      e_base_r <= repel_gain_r * rad_gap;
      e_dr_r   <= root_d * infl_radius_r;
      e_s_r    <= sq_s_r[NS-1];
      e_ax_r   <= sq_ax_r[NS-1];
      e_ay_r   <= sq_ay_r[NS-1];
    end
  end

  // Divisor and per-axis numerators
  logic [pff_pkg::DEN_W-1:0] f_den_r;
  logic [pff_pkg::NUM_W-1:0] f_nx_r, f_ny_r;
  always_ff @(posedge clk) begin
    if (en) begin
      f_den_r <= e_dr_r * e_s_r;
      f_nx_r  <= e_base_r * e_ax_r;
      f_ny_r  <= e_base_r * e_ay_r;
    end
  end

  logic [pff_pkg::DIV_BITS-1:0] qx, qy;
  logic                         bigx, bigy;

  pff_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (f_nx_r),
    .den (f_den_r),
    .q   (qx),
    .big (bigx)
  );

  pff_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (f_ny_r),
    .den (f_den_r),
    .q   (qy),
    .big (bigy)
  );

  // Cap, sign, sum and clamp
  pff_pkg::side_t              fin;
  logic [pff_pkg::DIV_BITS-1:0] repx, repy;
  logic signed [42:0]           sx, sy, totx, toty;
  logic                         hix, lox, hiy, loy;
  localparam logic signed [42:0] MAX32 = 43'sd2147483647;
  localparam logic signed [42:0] MIN32 = -43'sd2147483648;

  assign fin  = sd_r[pff_pkg::DIV_LAST];
  assign repx = (bigx || qx > pff_pkg::REP_CAP) ? pff_pkg::REP_CAP : qx;
  assign repy = (bigy || qy > pff_pkg::REP_CAP) ? pff_pkg::REP_CAP : qy;
  assign sx   = !fin.active ? '0 :
                fin.negx ? -$signed({2'b0, repx}) : $signed({2'b0, repx});
  assign sy   = !fin.active ? '0 :
                fin.negy ? -$signed({2'b0, repy}) : $signed({2'b0, repy});
  assign totx = 43'(fin.fx) + sx;
  assign toty = 43'(fin.fy) + sy;
  assign hix  = totx > MAX32;
  assign lox  = totx < MIN32;
  assign hiy  = toty > MAX32;
  assign loy  = toty < MIN32;

  always_ff @(posedge clk) begin
    if (en) begin
      out_force_x          <= hix ? 32'sh7FFFFFFF : lox ? 32'sh80000000 : totx[31:0];
      out_force_y          <= hiy ? 32'sh7FFFFFFF : loy ? 32'sh80000000 : toty[31:0];
      out_repulsion_active <= fin.active;
      out_saturated        <= hix || lox || hiy || loy;
    end
  end

  assign out_valid = vld_r[pff_pkg::NSTG-1];

endmodule
`default_nettype wire
